FILE: hw/rtl/chte_pkg.sv
// Package: shared constants, types and codes of the chained hash table engine.
`timescale 1ns / 1ps
`default_nettype none
package chte_pkg;
	localparam int unsigned BUCKETS_DEF = 64;
	localparam int unsigned SLACK_DEF   = 4;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_LOOKUP = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EXISTS   = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_HEAD,
		S_HEADW,
		S_RDENT,
		S_CMP,
		S_SPARE,
		S_SPAREW,
		S_INS,
		S_UNLINK,
		S_FREE,
		S_DONE
	} state_t;
endpackage
`default_nettype wire

FILE: hw/rtl/chte_ent_mem.sv
// Entry store: key, value and link of every pool entry, one read and one write port.
`timescale 1ns / 1ps
`default_nettype none
module chte_ent_mem #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned AW    = 8,
	parameter int unsigned LW    = 9
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic          wkey_en,
	input  wire logic [63:0]   wkey,
	input  wire logic [63:0]   wvalue,
	input  wire logic [LW-1:0] wlink,
	input  wire logic [AW-1:0] raddr,
	output logic      [63:0]   rkey,
	output logic      [63:0]   rvalue,
	output logic      [LW-1:0] rlink
);
	logic [63:0]   key_mem   [DEPTH];
	logic [63:0]   value_mem [DEPTH];
	logic [LW-1:0] link_mem  [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			link_mem[waddr] <= wlink;
			if (wkey_en) begin
				key_mem[waddr]   <= wkey;
				value_mem[waddr] <= wvalue;
			end
		end
		rkey   <= key_mem[raddr];
		rvalue <= value_mem[raddr];
		rlink  <= link_mem[raddr];
	end
endmodule
`default_nettype wire

FILE: hw/rtl/chained_hash_table_engine_top.sv
// Top level: request sequencer with chain walk over the entry store and bucket head memories.
//
// Usage: send one item on the request channel (action, key, value_in) with
// valid/ready; one result (status, value_out) comes back on the result channel.
// Items are handled one at a time: ready is low from acceptance until the
// result has been taken. A chain walk reads one entry and compares its key
// in each pair of states S_RDENT and S_CMP through the single entry memory
// read port; an insert of a new key adds the spare list, pool check and link
// write states, a remove the unlink and free states.
// After reset a clearing pass sets every chain head and spare head to null,
// one bucket a cycle, during which no item is accepted.
// If the receiver stalls the result is held in its output register and no
// new item is accepted until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module chained_hash_table_engine_top
	import chte_pkg::*;
#(
	parameter int unsigned BUCKETS = BUCKETS_DEF,
	parameter int unsigned SLACK   = SLACK_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  action,
	input  wire logic [63:0] key,
	input  wire logic [63:0] value_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [1:0]  status,
	output logic      [63:0] value_out
);
	localparam int unsigned POOL = BUCKETS * SLACK;
	localparam int unsigned AW   = (POOL > 1) ? $clog2(POOL) : 1;
	localparam int unsigned LW   = $clog2(POOL + 1);
	localparam int unsigned BW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam logic [LW-1:0] NIL = LW'(POOL);

	state_t state_q, state_d;

	logic [1:0]    act_q;
	logic [63:0]   key_q, val_q;
	logic [BW-1:0] bkt_q;
	logic [LW-1:0] cur_q, prev_q, spare_q, head_q, clr_q;
	logic [LW-1:0] pool_q;
	logic          is_head_q;

	// bucket head memories
	logic [LW-1:0] chain_mem [BUCKETS];
	logic [LW-1:0] spare_mem [BUCKETS];
	logic [LW-1:0] chain_rd, spare_rd;
	logic [BW-1:0] hw_addr;
	logic          cw_en, sw_en;
	logic [LW-1:0] cw_data, sw_data;

	always_ff @(posedge clk) begin
		if (cw_en) chain_mem[hw_addr] <= cw_data;
		if (sw_en) spare_mem[hw_addr] <= sw_data;
		chain_rd <= chain_mem[bkt_q];
		spare_rd <= spare_mem[bkt_q];
	end

	// entry store
	logic          e_we, e_wkey;
	logic [AW-1:0] e_waddr, e_raddr;
	logic [LW-1:0] e_wlink;
	logic [63:0]   e_rkey, e_rval;
	logic [LW-1:0] e_rlink;

	chte_ent_mem #(.DEPTH(POOL), .AW(AW), .LW(LW)) u_mem (
		.clk(clk), .we(e_we), .waddr(e_waddr), .wkey_en(e_wkey), .wkey(key_q),
		.wvalue(val_q), .wlink(e_wlink), .raddr(e_raddr),
		.rkey(e_rkey), .rvalue(e_rval), .rlink(e_rlink)
	);

	logic hit;
	assign hit = (e_rkey == key_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR:  if (clr_q == LW'(BUCKETS - 1) || BUCKETS == 1) state_d = S_IDLE;
			S_IDLE:   if (in_valid) state_d = S_HEAD;
			S_HEAD:   state_d = S_HEADW;
			S_HEADW:  state_d = S_RDENT;
			S_RDENT:  state_d = (cur_q == NIL) ? ((act_q == ACT_INSERT) ? S_SPARE : S_DONE)
				: S_CMP;
			S_CMP:    state_d = hit ? ((act_q == ACT_REMOVE) ? S_UNLINK : S_DONE) : S_RDENT;
			S_SPARE:  state_d = (spare_q != NIL) ? S_SPAREW
				: ((pool_q != NIL) ? S_INS : S_DONE);
			S_SPAREW: state_d = S_INS;
			S_INS:    state_d = S_DONE;
			S_UNLINK: state_d = S_FREE;
			S_FREE:   state_d = S_DONE;
			S_DONE:   if (out_ready) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == S_IDLE);
		out_valid = (state_q == S_DONE);
		cw_en = 1'b0; sw_en = 1'b0; cw_data = '0; sw_data = '0; hw_addr = bkt_q;
		e_we = 1'b0; e_wkey = 1'b0; e_waddr = cur_q[AW-1:0]; e_wlink = '0;
		e_raddr = cur_q[AW-1:0];
		unique case (state_q)
			S_CLEAR: begin
				cw_en = 1'b1; sw_en = 1'b1; cw_data = NIL; sw_data = NIL;
				hw_addr = clr_q[BW-1:0];
			end
			S_SPARE, S_SPAREW: e_raddr = spare_q[AW-1:0];
			S_INS: begin
				e_we = 1'b1; e_wkey = 1'b1; e_wlink = head_q;
				e_waddr = (spare_q != NIL) ? spare_q[AW-1:0] : pool_q[AW-1:0];
				cw_en = 1'b1;
				cw_data = (spare_q != NIL) ? spare_q : pool_q;
				sw_en = (spare_q != NIL); sw_data = e_rlink;
			end
			S_UNLINK: begin
				if (is_head_q) begin
					cw_en = 1'b1; cw_data = e_rlink;
				end else begin
					e_we = 1'b1; e_waddr = prev_q[AW-1:0]; e_wlink = e_rlink;
				end
			end
			S_FREE: begin
				e_we = 1'b1; e_waddr = cur_q[AW-1:0]; e_wlink = spare_q;
				sw_en = 1'b1; sw_data = cur_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			pool_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == S_INS && spare_q == NIL) pool_q <= pool_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (in_valid) begin
				act_q <= action; key_q <= key; val_q <= value_in;
				bkt_q <= BW'(key % 64'(BUCKETS));
			end
			S_HEADW: begin
				cur_q <= chain_rd; head_q <= chain_rd; spare_q <= spare_rd;
				prev_q <= NIL; is_head_q <= 1'b1;
				status <= ST_NOTFOUND; value_out <= '0;
				if (act_q != ACT_INSERT && act_q != ACT_LOOKUP && act_q != ACT_REMOVE)
					cur_q <= NIL;
			end
			S_RDENT: if (cur_q == NIL && act_q == ACT_INSERT) status <= ST_FULL;
			S_CMP: begin
				if (hit) begin
					if (act_q == ACT_INSERT) begin
						status <= ST_EXISTS;
					end else begin
						status <= ST_OK; value_out <= e_rval;
					end
				end else begin
					prev_q <= cur_q; cur_q <= e_rlink; is_head_q <= 1'b0;
				end
			end
			S_INS: status <= ST_OK;
			default: ;
		endcase
	end
endmodule
`default_nettype wire
